// ===== src/fss_pkg.sv =====
`default_nettype none

package fss_pkg;

    localparam int MAX_QUERY = 16;

    // query position / length counters; must hold MAX_QUERY + 1
    localparam int POS_W   = 5;
    localparam int IDX_W   = 4;
    localparam int ACC_W   = 8;
    localparam int SCORE_W = 11;
    localparam int CFG_W   = 64;

    localparam logic [POS_W-1:0]   QLEN_MAX     = POS_W'(MAX_QUERY);
    localparam logic [POS_W-1:0]   LEN_SAT      = POS_W'(MAX_QUERY + 1);
    localparam logic [SCORE_W-1:0] EXACT_BONUS  = SCORE_W'(1000);
    localparam logic [SCORE_W-1:0] PREFIX_BONUS = SCORE_W'(100);

    typedef enum logic [1:0] {
        CFG_QUERY_LEN  = 2'd0,
        CFG_CHARS_LOW  = 2'd1,
        CFG_CHARS_HIGH = 2'd2
    } cfg_reg_t;

    // ASCII upper case to lower case, other bytes unchanged
    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5a)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    function automatic logic [7:0] query_byte(
        input logic [CFG_W-1:0] lo,
        input logic [CFG_W-1:0] hi,
        input logic [IDX_W-1:0] idx
    );
        logic [7:0] r;
        if (idx[3])
        begin
            r = hi[idx[2:0]*8 +: 8];
        end
        else
        begin
            r = lo[idx[2:0]*8 +: 8];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== src/fuzzy_subsequence_scorer.sv =====
// Case-insensitive fuzzy subsequence scorer. Stream a candidate string one
// byte word per cycle; the query (up to 16 chars) sits in configuration
// registers and may only be rewritten between candidates. The block takes one
// word every clock unless stalled. The last_char word yields one result word
// in the output register on the next cycle; that register parts the two
// channels, so in_stall is raised only while it holds an untaken result and
// out_stall is high. A word with empty_cand set adds no byte; with last_char
// it closes an empty candidate. Score: each match adds its current run
// length, plus 1000 for an exact-length match or 100 for a longer candidate
// that starts with the query. An empty query always matches with score 0.
`default_nettype none

module fuzzy_subsequence_scorer
    import fss_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 cfg_we,
    input  wire logic [1:0]           cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [7:0]           char_in,
    input  wire logic                 last_char,
    input  wire logic                 empty_cand,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic                      matched,
    output logic [SCORE_W-1:0]        score
);

    logic [POS_W-1:0]   query_len_reg;
    logic [CFG_W-1:0]   chars_low_reg;
    logic [CFG_W-1:0]   chars_high_reg;

    logic [POS_W-1:0]   query_pos_reg,   query_pos_next;
    logic [POS_W-1:0]   run_len_reg,     run_len_next;
    logic [ACC_W-1:0]   score_acc_reg,   score_acc_next;
    logic [POS_W-1:0]   length_seen_reg, length_seen_next;
    logic               prefix_ok_reg,   prefix_ok_next;

    logic               out_valid_reg,   out_valid_next;
    logic               matched_reg,     matched_next;
    logic [SCORE_W-1:0] score_reg,       score_next;

    logic               accept;
    logic [POS_W-1:0]   qlen;
    logic [7:0]         lc;
    logic [7:0]         q_at_pos;
    logic [7:0]         q_at_len;
    logic               all_found;
    logic [SCORE_W-1:0] bonus;

    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    assign qlen     = (query_len_reg > QLEN_MAX) ? QLEN_MAX : query_len_reg;
    assign lc       = fold_case(char_in);
    assign q_at_pos = fold_case(query_byte(chars_low_reg, chars_high_reg,
                                           query_pos_reg[IDX_W-1:0]));
    assign q_at_len = fold_case(query_byte(chars_low_reg, chars_high_reg,
                                           length_seen_reg[IDX_W-1:0]));

    // per-word candidate update
    always_comb
    begin
        query_pos_next   = query_pos_reg;
        run_len_next     = run_len_reg;
        score_acc_next   = score_acc_reg;
        length_seen_next = length_seen_reg;
        prefix_ok_next   = prefix_ok_reg;
        if (!empty_cand)
        begin
            if (query_pos_reg < qlen && lc == q_at_pos)
            begin
                query_pos_next = query_pos_reg + POS_W'(1);
                run_len_next   = run_len_reg + POS_W'(1);
                score_acc_next = score_acc_reg + ACC_W'(run_len_next);
            end
            else
            begin
                run_len_next = '0;
            end
            if (length_seen_reg < qlen && lc != q_at_len)
            begin
                prefix_ok_next = 1'b0;
            end
            if (length_seen_reg < LEN_SAT)
            begin
                length_seen_next = length_seen_reg + POS_W'(1);
            end
        end
    end

    // result for a closing word
    always_comb
    begin
        all_found = (query_pos_next >= qlen);
        bonus     = '0;
        if (length_seen_next == qlen)
        begin
            bonus = EXACT_BONUS;
        end
        else if (length_seen_next > qlen && prefix_ok_next)
        begin
            bonus = PREFIX_BONUS;
        end

        if (qlen == '0)
        begin
            matched_next = 1'b1;
            score_next   = '0;
        end
        else if (all_found)
        begin
            matched_next = 1'b1;
            score_next   = SCORE_W'(score_acc_next) + bonus;
        end
        else
        begin
            matched_next = 1'b0;
            score_next   = '0;
        end

        if (accept && last_char)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_len_reg  <= '0;
            chars_low_reg  <= '0;
            chars_high_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_QUERY_LEN:  query_len_reg  <= cfg_data[POS_W-1:0];
                CFG_CHARS_LOW:  chars_low_reg  <= cfg_data;
                CFG_CHARS_HIGH: chars_high_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            query_pos_reg   <= '0;
            run_len_reg     <= '0;
            score_acc_reg   <= '0;
            length_seen_reg <= '0;
            prefix_ok_reg   <= 1'b1;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (accept)
            begin
                if (last_char)
                begin
                    query_pos_reg   <= '0;
                    run_len_reg     <= '0;
                    score_acc_reg   <= '0;
                    length_seen_reg <= '0;
                    prefix_ok_reg   <= 1'b1;
                end
                else
                begin
                    query_pos_reg   <= query_pos_next;
                    run_len_reg     <= run_len_next;
                    score_acc_reg   <= score_acc_next;
                    length_seen_reg <= length_seen_next;
                    prefix_ok_reg   <= prefix_ok_next;
                end
            end
        end
    end

    // result payload, loaded only by a closing word
    always_ff @(posedge clk)
    begin
        if (accept && last_char)
        begin
            matched_reg <= matched_next;
            score_reg   <= score_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;
    assign score     = score_reg;

endmodule

`default_nettype wire
